### rtl/core/assert_macros.svh
// assertion macros of the cipher engine, used by bce_ctrl
// expects clk and rst_n in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BCE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BCE_ASSERT_NOW(label, ante, cons)
`define BCE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/bce_pkg.sv
// shared types and constants of the blowfish cipher engine
// no dependencies
`default_nettype none
package bce_pkg;

    localparam int P_IDX_W   = 5;
    localparam int KEY_IDX_W = 4;
    localparam int S_ADDR_W  = 10;

    typedef enum logic [2:0] {
        ACT_LOAD_P   = 3'd0,
        ACT_LOAD_S   = 3'd1,
        ACT_LOAD_KEY = 3'd2,
        ACT_EXPAND   = 3'd3,
        ACT_ENCRYPT  = 3'd4,
        ACT_DECRYPT  = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KXOR,
        ST_RA,
        ST_RB,
        ST_FIN,
        ST_SWR,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MODE_BLOCK,
        MODE_EXP_P,
        MODE_EXP_S
    } mode_t;

    typedef struct packed {
        logic                 accept;
        logic                 load_in;
        logic                 zero_lr;
        logic                 kxor;
        logic                 round_a;
        logic                 round_b;
        logic                 dec;
        logic                 fin_out;
        logic                 done_out;
        logic                 p_wr_pair;
        logic                 s_wr_l;
        logic                 s_wr_r;
        logic [P_IDX_W-1:0]   p_sel;
        logic [KEY_IDX_W-1:0] k_sel;
        logic [S_ADDR_W-1:0]  s_addr;
    } bce_cmd_t;

    typedef struct packed {
        logic out_busy;
    } bce_status_t;

endpackage
`default_nettype wire

### rtl/core/blowfish_cipher_engine_unit.sv
// blowfish engine: loads p, s and key words, expands keys, encrypts and decrypts
// block: per round an s-box read then f and swap, then whitening into the result register,
// held while the last result is not taken; a new block is accepted once the last is done
// expansion: key xor into p, chained encryptions from a zero block fill p and s in pairs
// reset: control and result valid clear, key_word_count 14, tables undefined until loaded
// depends on bce_pkg, bce_ctrl, bce_datapath
`default_nettype none
module blowfish_cipher_engine_unit #(
    parameter int ROUND_COUNT   = 16,
    parameter int MAX_KEY_WORDS = 14
) (
    input  wire          clk,
    input  wire          rst_n,
    // input items
    input  wire          s_tvalid,
    output logic         s_tready,
    // index [9:0], word [41:10], block_left [73:42], block_right [105:74], zero pad
    input  wire  [111:0] s_tdata,
    // action [2:0]
    input  wire  [2:0]   s_tuser,
    // result items
    output logic         m_tvalid,
    input  wire          m_tready,
    // result_left [31:0], result_right [63:32]
    output logic [63:0]  m_tdata,
    // result_kind [0]
    output logic [0:0]   m_tuser,
    // key word count register
    input  wire          cfg_we,
    input  wire  [3:0]   cfg_wdata
);
    import bce_pkg::*;

    bce_cmd_t    cmd;
    bce_status_t status;
    logic        result_kind;
    logic [31:0] result_left, result_right;

    // sequencer: one item at a time, ready only while idle
    bce_ctrl #(
        .ROUND_COUNT   (ROUND_COUNT),
        .MAX_KEY_WORDS (MAX_KEY_WORDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .action    (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .cmd       (cmd)
    );

    // tables, halves and the result register
    bce_datapath #(
        .ROUND_COUNT   (ROUND_COUNT),
        .MAX_KEY_WORDS (MAX_KEY_WORDS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .action       (s_tuser),
        .index        (s_tdata[9:0]),
        .word         (s_tdata[41:10]),
        .block_left   (s_tdata[73:42]),
        .block_right  (s_tdata[105:74]),
        .m_tready     (m_tready),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .result_kind  (result_kind),
        .result_left  (result_left),
        .result_right (result_right)
    );

    assign m_tdata = {result_right, result_left};
    assign m_tuser = result_kind;

endmodule
`default_nettype wire

### rtl/core/bce_ctrl.sv
// sequencer of the cipher engine: rounds, key expansion, handshake
// depends on bce_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module bce_ctrl #(
    parameter int ROUND_COUNT   = 16,
    parameter int MAX_KEY_WORDS = 14
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [2:0]           action,
    input  wire                  cfg_we,
    input  wire  [3:0]           cfg_wdata,
    input  bce_pkg::bce_status_t status,
    output bce_pkg::bce_cmd_t    cmd
);
    import bce_pkg::*;

    localparam int PW = ROUND_COUNT + 2;
    localparam int RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

    state_t               state_reg, state_next;
    mode_t                mode_reg, mode_next;
    logic [RW-1:0]        round_reg, round_next;
    logic                 dec_reg, dec_next;
    logic [P_IDX_W-1:0]   pidx_reg, pidx_next;
    logic [KEY_IDX_W-1:0] kidx_reg, kidx_next;
    logic [8:0]           sidx_reg, sidx_next;
    logic [3:0]           kcount_reg;
    logic [3:0]           kcount;
    logic                 accept;
    logic [P_IDX_W:0]     pidx_plus2;
    logic                 fin_stall;

    // effective key word count
    always_comb
    begin
        if (kcount_reg == 4'd0)
            kcount = 4'd1;
        else if (kcount_reg > 4'(MAX_KEY_WORDS))
            kcount = 4'(MAX_KEY_WORDS);
        else
            kcount = kcount_reg;
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign pidx_plus2 = {1'b0, pidx_reg} + (P_IDX_W+1)'(2);
    assign fin_stall  = state_reg == ST_FIN && mode_reg == MODE_BLOCK && status.out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mode_reg   <= MODE_BLOCK;
            round_reg  <= '0;
            dec_reg    <= 1'b0;
            pidx_reg   <= '0;
            kidx_reg   <= '0;
            sidx_reg   <= '0;
            kcount_reg <= 4'd14;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            round_reg <= round_next;
            dec_reg   <= dec_next;
            pidx_reg  <= pidx_next;
            kidx_reg  <= kidx_next;
            sidx_reg  <= sidx_next;
            if (cfg_we)
                kcount_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        round_next = round_reg;
        dec_next   = dec_reg;
        pidx_next  = pidx_reg;
        kidx_next  = kidx_reg;
        sidx_next  = sidx_reg;
        cmd        = '0;
        cmd.accept = accept;
        cmd.dec    = dec_reg;
        cmd.k_sel  = kidx_reg;
        cmd.p_sel  = pidx_reg;
        cmd.s_addr = {sidx_reg, 1'b0};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_ENCRYPT || action == ACT_DECRYPT)
                    begin
                        cmd.load_in = 1'b1;
                        dec_next    = (action == ACT_DECRYPT);
                        round_next  = '0;
                        mode_next   = MODE_BLOCK;
                        state_next  = ST_RA;
                    end
                    else if (action == ACT_EXPAND)
                    begin
                        cmd.zero_lr = 1'b1;
                        pidx_next   = '0;
                        kidx_next   = '0;
                        state_next  = ST_KXOR;
                    end
                end
            end
            ST_KXOR:
            begin
                cmd.kxor  = 1'b1;
                pidx_next = pidx_reg + P_IDX_W'(1);
                if (kidx_reg + KEY_IDX_W'(1) >= kcount)
                    kidx_next = '0;
                else
                    kidx_next = kidx_reg + KEY_IDX_W'(1);
                if (pidx_reg == P_IDX_W'(PW - 1))
                begin
                    pidx_next  = '0;
                    mode_next  = MODE_EXP_P;
                    round_next = '0;
                    dec_next   = 1'b0;
                    state_next = ST_RA;
                end
            end
            ST_RA:
            begin
                cmd.round_a = 1'b1;
                if (dec_reg)
                    cmd.p_sel = P_IDX_W'(ROUND_COUNT + 1) - P_IDX_W'(round_reg);
                else
                    cmd.p_sel = P_IDX_W'(round_reg);
                state_next = ST_RB;
            end
            ST_RB:
            begin
                cmd.round_b = 1'b1;
                if (round_reg == RW'(ROUND_COUNT - 1))
                    state_next = ST_FIN;
                else
                begin
                    round_next = round_reg + RW'(1);
                    state_next = ST_RA;
                end
            end
            ST_FIN:
            begin
                case (mode_reg)
                    MODE_BLOCK:
                    begin
                        if (!status.out_busy)
                        begin
                            cmd.fin_out = 1'b1;
                            state_next  = ST_IDLE;
                        end
                    end
                    MODE_EXP_P:
                    begin
                        cmd.p_wr_pair = 1'b1;
                        round_next    = '0;
                        state_next    = ST_RA;
                        if (pidx_plus2 >= (P_IDX_W+1)'(PW))
                        begin
                            mode_next = MODE_EXP_S;
                            sidx_next = '0;
                        end
                        else
                            pidx_next = pidx_plus2[P_IDX_W-1:0];
                    end
                    default:
                    begin
                        cmd.s_wr_l = 1'b1;
                        state_next = ST_SWR;
                    end
                endcase
            end
            ST_SWR:
            begin
                cmd.s_wr_r = 1'b1;
                cmd.s_addr = {sidx_reg, 1'b1};
                if (sidx_reg == 9'h1FF)
                    state_next = ST_DONE;
                else
                begin
                    sidx_next  = sidx_reg + 9'd1;
                    round_next = '0;
                    state_next = ST_RA;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.done_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `BCE_ASSERT_NEXT(a_enc_starts, accept && action == ACT_ENCRYPT, state_reg == ST_RA)
    `BCE_ASSERT_NOW(a_round_bound, state_reg == ST_RB, round_reg <= RW'(ROUND_COUNT - 1))
    `BCE_ASSERT_NEXT(a_fin_holds, fin_stall, state_reg == ST_FIN)
    `BCE_ASSERT_NOW(a_swr_mode, state_reg == ST_SWR, mode_reg == MODE_EXP_S)

endmodule
`default_nettype wire

### rtl/core/bce_datapath.sv
// datapath of the cipher engine: p array, key store, s-box banks, round logic
// depends on bce_pkg
`default_nettype none
module bce_datapath #(
    parameter int ROUND_COUNT   = 16,
    parameter int MAX_KEY_WORDS = 14
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  bce_pkg::bce_cmd_t    cmd,
    input  wire  [2:0]           action,
    input  wire  [9:0]           index,
    input  wire  [31:0]          word,
    input  wire  [31:0]          block_left,
    input  wire  [31:0]          block_right,
    input  wire                  m_tready,
    output bce_pkg::bce_status_t status,
    output logic                 m_tvalid,
    output logic                 result_kind,
    output logic [31:0]          result_left,
    output logic [31:0]          result_right
);
    import bce_pkg::*;

    localparam int PW  = ROUND_COUNT + 2;
    localparam int PIW = $clog2(PW);
    localparam int KIW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;

    logic [31:0] p_reg [PW];
    logic [31:0] key_reg [MAX_KEY_WORDS];
    logic [31:0] sbox_mem [4][256];
    logic [31:0] s_rd_reg [4];
    logic [31:0] l_reg, r_reg;
    logic        out_valid_reg;
    logic        kind_reg;
    logic [31:0] res_l_reg, res_r_reg;

    logic [31:0] p_rd, k_rd, l_xp, f_val, fin_l, fin_r;
    logic [31:0] p_lo, p_hi;
    logic [P_IDX_W:0] p_sel_plus1;
    logic        load_p, load_s, load_k;

    assign load_p = cmd.accept && action == ACT_LOAD_P && index < 10'(PW);
    assign load_s = cmd.accept && action == ACT_LOAD_S;
    assign load_k = cmd.accept && action == ACT_LOAD_KEY && index < 10'(MAX_KEY_WORDS);

    assign p_rd = p_reg[cmd.p_sel[PIW-1:0]];
    assign k_rd = key_reg[cmd.k_sel[KIW-1:0]];
    assign l_xp = l_reg ^ p_rd;
    assign f_val = ((s_rd_reg[0] + s_rd_reg[1]) ^ s_rd_reg[2]) + s_rd_reg[3];
    assign p_sel_plus1 = {1'b0, cmd.p_sel} + (P_IDX_W+1)'(1);

    // output whitening words
    always_comb
    begin
        if (cmd.dec)
        begin
            p_lo = p_reg[0];
            p_hi = p_reg[1];
        end
        else
        begin
            p_lo = p_reg[PW - 1];
            p_hi = p_reg[PW - 2];
        end
    end
    assign fin_l = r_reg ^ p_lo;
    assign fin_r = l_reg ^ p_hi;

    // p array
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PW; i++)
        begin
            if (load_p && index[PIW-1:0] == PIW'(i))
                p_reg[i] <= word;
            else if (cmd.kxor && cmd.p_sel == P_IDX_W'(i))
                p_reg[i] <= p_reg[i] ^ k_rd;
            else if (cmd.p_wr_pair && cmd.p_sel == P_IDX_W'(i))
                p_reg[i] <= fin_l;
            else if (cmd.p_wr_pair && p_sel_plus1 == (P_IDX_W+1)'(i))
                p_reg[i] <= fin_r;
        end
    end

    // key store
    always_ff @(posedge clk)
    begin
        if (load_k)
            key_reg[index[KIW-1:0]] <= word;
    end

    // four s-box banks, one per byte lane
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic        wr_en;
        logic [7:0]  wr_addr;
        logic [31:0] wr_data;
        logic [7:0]  rd_addr;

        always_comb
        begin
            wr_en   = 1'b0;
            wr_addr = cmd.s_addr[7:0];
            wr_data = fin_l;
            if (load_s && index[9:8] == 2'(b))
            begin
                wr_en   = 1'b1;
                wr_addr = index[7:0];
                wr_data = word;
            end
            else if (cmd.s_wr_l && cmd.s_addr[9:8] == 2'(b))
                wr_en = 1'b1;
            else if (cmd.s_wr_r && cmd.s_addr[9:8] == 2'(b))
            begin
                wr_en   = 1'b1;
                wr_data = r_reg;
            end
        end

        assign rd_addr = l_xp[31 - 8*b -: 8];

        always_ff @(posedge clk)
        begin
            if (wr_en)
                sbox_mem[b][wr_addr] <= wr_data;
            s_rd_reg[b] <= sbox_mem[b][rd_addr];
        end
    end

    // block halves
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            l_reg <= block_left;
            r_reg <= block_right;
        end
        else if (cmd.zero_lr)
        begin
            l_reg <= '0;
            r_reg <= '0;
        end
        else if (cmd.round_a)
            l_reg <= l_xp;
        else if (cmd.round_b)
        begin
            l_reg <= r_reg ^ f_val;
            r_reg <= l_reg;
        end
        else if (cmd.p_wr_pair || cmd.s_wr_l)
        begin
            l_reg <= fin_l;
            r_reg <= fin_r;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.fin_out || cmd.done_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_out)
        begin
            kind_reg  <= 1'b0;
            res_l_reg <= fin_l;
            res_r_reg <= fin_r;
        end
        else if (cmd.done_out)
        begin
            kind_reg  <= 1'b1;
            res_l_reg <= '0;
            res_r_reg <= '0;
        end
    end

    assign status.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid        = out_valid_reg;
    assign result_kind     = kind_reg;
    assign result_left     = res_l_reg;
    assign result_right    = res_r_reg;

endmodule
`default_nettype wire
